@@ rtl/qth_pkg.sv @@
package qth_pkg;

    localparam int CFG_W            = 7;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;
    localparam int COUNT_W          = 32;
    localparam int MAX_LEVELS_DEF   = 64;
    localparam int MAX_READ_LEN_DEF = 64;

    localparam logic [CFG_W-1:0] QUAL_OFFSET_RST = CFG_W'(33);
    localparam logic [CFG_W-1:0] MIN_LEVEL_RST   = CFG_W'(0);
    localparam logic [CFG_W-1:0] NUM_LEVELS_RST  = CFG_W'(64);
    localparam logic [CFG_W-1:0] READ_LEN_RST    = CFG_W'(64);

    typedef enum logic [1:0] {
        REG_QUAL_OFFSET = 2'd0,
        REG_MIN_LEVEL   = 2'd1,
        REG_NUM_LEVELS  = 2'd2,
        REG_READ_LEN    = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_SKIP = 3'd1,
        ST_HIGH = 3'd2,
        ST_LONG = 3'd3,
        ST_HALT = 3'd4,
        ST_ADDR = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR1,
        S_ADDR2,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic       opcode;
        logic [7:0] quality;
        logic       first_of_read;
        logic [5:0] read_position;
        logic [5:0] prev_level;
        logic [5:0] level;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [2:0]         status;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic calc1;
        logic calc2;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_mem;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/qth_ram.sv @@
module qth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/qth_ctrl.sv @@
module qth_ctrl
    import qth_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.need_mem ? S_ADDR1 : S_DONE;
                end
            end
            S_ADDR1: begin
                o_cmd.calc1 = 1'b1;
                n_state     = S_ADDR2;
            end
            S_ADDR2: begin
                o_cmd.calc2 = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/qth_dp.sv @@
module qth_dp
    import qth_pkg::*;
#(
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
    parameter int MAX_READ_LEN = MAX_READ_LEN_DEF,
    localparam int DEPTH = MAX_LEVELS + MAX_LEVELS * MAX_LEVELS * (MAX_READ_LEN - 1),
    localparam int A_W   = $clog2(DEPTH),
    localparam int NL_W  = $clog2(MAX_LEVELS + 1),
    localparam int RL_W  = $clog2(MAX_READ_LEN + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  t_in_word         i_in_word,
    input  logic [CFG_W-1:0] i_qual_offset,
    input  logic [CFG_W-1:0] i_min_level,
    input  logic [NL_W-1:0]  i_eff_levels,
    input  logic [RL_W-1:0]  i_eff_len,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    localparam int LVL_W = $clog2(MAX_LEVELS);
    localparam int POS_W = $clog2(MAX_READ_LEN);
    localparam int PC_W  = RL_W;
    localparam int T_W   = $clog2(MAX_LEVELS * (MAX_READ_LEN - 1));

    // per-read tracking state
    logic [PC_W-1:0]  r_position, n_position;
    logic             r_skip_read, n_skip_read;
    logic             r_fault, n_fault;
    logic [LVL_W-1:0] r_last_level, n_last_level;
    logic             r_last_below, n_last_below;

    // decoded item
    t_status          r_status, n_status;
    logic             r_need_mem, n_need_mem;
    logic             r_bump, n_bump;
    logic             r_is_start, n_is_start;
    logic [POS_W-1:0] r_rm1, n_rm1;
    logic [LVL_W-1:0] r_p, n_p;
    logic [LVL_W-1:0] r_c, n_c;

    logic [T_W-1:0]   r_t;
    logic [A_W-1:0]   r_addr;
    logic [A_W-1:0]   r_clr_addr;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic signed [9:0]  w_b;
    logic               w_neg;
    logic               w_b_ge_nl;
    logic               w_start;
    logic [COUNT_W-1:0] w_rdata;
    logic [COUNT_W-1:0] w_sat;
    logic               w_we;
    logic [A_W-1:0]     w_waddr;
    logic [COUNT_W-1:0] w_wdata;

    assign w_b = $signed({2'b00, i_in_word.quality})
               - $signed({3'b000, i_qual_offset})
               - $signed({3'b000, i_min_level});
    assign w_neg     = w_b[9];
    assign w_b_ge_nl = !w_neg && (32'(w_b[8:0]) >= 32'(i_eff_levels));
    assign w_start   = i_in_word.first_of_read || (r_position == '0);

    always_comb begin
        n_position   = r_position;
        n_skip_read  = r_skip_read;
        n_fault      = r_fault;
        n_last_level = r_last_level;
        n_last_below = r_last_below;
        n_status     = ST_OK;
        n_need_mem   = 1'b0;
        n_bump       = 1'b0;
        n_is_start   = 1'b0;
        n_rm1        = POS_W'(7'(i_in_word.read_position) - 7'd1);
        n_p          = LVL_W'(i_in_word.prev_level);
        n_c          = LVL_W'(i_in_word.level);
        if (i_in_word.opcode == OP_READ) begin
            if (32'(i_in_word.prev_level) >= 32'(i_eff_levels)) begin
                n_status = ST_ADDR;
            end else if (i_in_word.read_position == '0) begin
                n_need_mem = 1'b1;
                n_is_start = 1'b1;
            end else if ((32'(i_in_word.level) >= 32'(i_eff_levels)) ||
                         (32'(i_in_word.read_position) >= 32'(i_eff_len))) begin
                n_status = ST_ADDR;
            end else begin
                n_need_mem = 1'b1;
            end
        end else if (r_fault) begin
            n_status = ST_HALT;
        end else if (w_start) begin
            n_position = PC_W'(1);
            if (w_neg) begin
                n_skip_read = 1'b1;
                n_status    = ST_SKIP;
            end else if (w_b_ge_nl) begin
                n_fault  = 1'b1;
                n_status = ST_HIGH;
            end else begin
                n_skip_read  = 1'b0;
                n_last_level = LVL_W'(w_b[8:0]);
                n_last_below = 1'b0;
                n_need_mem   = 1'b1;
                n_bump       = 1'b1;
                n_is_start   = 1'b1;
                n_p          = LVL_W'(w_b[8:0]);
            end
        end else if (32'(r_position) >= 32'(i_eff_len)) begin
            n_fault  = 1'b1;
            n_status = ST_LONG;
        end else if (r_skip_read) begin
            n_position = r_position + PC_W'(1);
            n_status   = ST_SKIP;
        end else if (w_b_ge_nl) begin
            n_fault  = 1'b1;
            n_status = ST_HIGH;
        end else begin
            n_position = r_position + PC_W'(1);
            n_rm1      = POS_W'(r_position - PC_W'(1));
            n_p        = r_last_level;
            n_c        = LVL_W'(w_b[8:0]);
            if (w_neg || r_last_below) begin
                n_status = ST_SKIP;
            end else begin
                n_need_mem = 1'b1;
                n_bump     = 1'b1;
            end
            n_last_below = w_neg;
            n_last_level = w_neg ? '0 : LVL_W'(w_b[8:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position   <= '0;
            r_skip_read  <= 1'b0;
            r_fault      <= 1'b0;
            r_last_level <= '0;
            r_last_below <= 1'b1;
            r_clr_addr   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_position   <= n_position;
                r_skip_read  <= n_skip_read;
                r_fault      <= n_fault;
                r_last_level <= n_last_level;
                r_last_below <= n_last_below;
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + A_W'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // decoded item, address arithmetic over two steps (one constant multiply each) and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status   <= n_status;
            r_need_mem <= n_need_mem;
            r_bump     <= n_bump;
            r_is_start <= n_is_start;
            r_rm1      <= n_rm1;
            r_p        <= n_p;
            r_c        <= n_c;
        end
        if (i_cmd.calc1) begin
            r_t <= T_W'(r_rm1) * T_W'(MAX_LEVELS) + T_W'(r_p);
        end
        if (i_cmd.calc2) begin
            r_addr <= r_is_start ? A_W'(r_p)
                    : A_W'(MAX_LEVELS) + A_W'(r_t) * A_W'(MAX_LEVELS) + A_W'(r_c);
        end
        if (i_cmd.finish) begin
            r_out_word.status <= r_status;
            r_out_word.count  <= !r_need_mem ? '0 : (r_bump ? w_sat : w_rdata);
        end
    end

    assign w_sat   = (&w_rdata) ? w_rdata : w_rdata + COUNT_W'(1);
    assign w_we    = i_cmd.clear || (i_cmd.finish && r_bump);
    assign w_waddr = i_cmd.clear ? r_clr_addr : r_addr;
    assign w_wdata = i_cmd.clear ? '0 : w_sat;

    qth_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign o_stat.clear_last = (r_clr_addr == A_W'(DEPTH - 1));
    assign o_stat.need_mem   = n_need_mem;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

endmodule

@@ rtl/quality_transition_histogram.sv @@
// A word that touches the count store passes the address steps S_ADDR1 and S_ADDR2
// and the registered store read in S_READ before S_DONE; any other word goes straight
// to S_DONE. There the result is loaded once the result register is free, and the
// input opens again as the result appears, so each word is handed over before the next
// is accepted. Reset (synchronous, active low) clears control state, then a pass zeroes
// all MAX_LEVELS + MAX_LEVELS^2*(MAX_READ_LEN-1) count store entries, one entry a cycle.
module quality_transition_histogram
    import qth_pkg::*;
#(
    parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
    parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    // result word channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int NL_W = $clog2(MAX_LEVELS + 1);
    localparam int RL_W = $clog2(MAX_READ_LEN + 1);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic [CFG_W-1:0] r_qual_offset;
    logic [CFG_W-1:0] r_min_level;
    logic [CFG_W-1:0] r_num_levels;
    logic [CFG_W-1:0] r_read_len;

    logic [NL_W-1:0]  w_eff_levels;
    logic [RL_W-1:0]  w_eff_len;
    logic             w_cfg_wr;
    t_reg_idx         w_reg_idx;
    t_cmd             w_cmd;
    t_stat            w_stat;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual_offset <= QUAL_OFFSET_RST;
            r_min_level   <= MIN_LEVEL_RST;
            r_num_levels  <= NUM_LEVELS_RST;
            r_read_len    <= READ_LEN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_QUAL_OFFSET: r_qual_offset <= pwdata[CFG_W-1:0];
                REG_MIN_LEVEL:   r_min_level   <= pwdata[CFG_W-1:0];
                REG_NUM_LEVELS:  r_num_levels  <= pwdata[CFG_W-1:0];
                REG_READ_LEN:    r_read_len    <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_reg_idx)
            REG_QUAL_OFFSET: prdata = PDATA_W'(r_qual_offset);
            REG_MIN_LEVEL:   prdata = PDATA_W'(r_min_level);
            REG_NUM_LEVELS:  prdata = PDATA_W'(r_num_levels);
            REG_READ_LEN:    prdata = PDATA_W'(r_read_len);
            default:         prdata = '0;
        endcase
    end

    // clamp the level count and read length to 1 .. the built size
    assign w_eff_levels = (r_num_levels == '0) ? NL_W'(1)
                        : (32'(r_num_levels) > 32'(MAX_LEVELS)) ? NL_W'(MAX_LEVELS)
                        : NL_W'(r_num_levels);
    assign w_eff_len    = (r_read_len == '0) ? RL_W'(1)
                        : (32'(r_read_len) > 32'(MAX_READ_LEN)) ? RL_W'(MAX_READ_LEN)
                        : RL_W'(r_read_len);

    // sequencer: clear, accept, address, read, write back and hand over
    qth_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // decode, read tracking, address arithmetic, count store and result register
    qth_dp #(
        .MAX_LEVELS   (MAX_LEVELS),
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_word     (i_in_word),
        .i_qual_offset (r_qual_offset),
        .i_min_level   (r_min_level),
        .i_eff_levels  (w_eff_levels),
        .i_eff_len     (w_eff_len),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_word    (o_out_word)
    );

    // a word that is not counted or read back carries a zero count
    a_zero_count_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != ST_OK)) |-> (o_out_word.count == '0))
        else $error("non-ok result carries a non-zero count");

    // one word in flight: input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // the result register is only loaded from a completed item, so it never
    // rises in the cycle straight after an acceptance
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared before the item was processed");

endmodule
